// ===== sv/bgcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgcd_pkg
// Shared constants and types for the binary GCD cell chain.
// ----------------------------------------------------------------------------
package bgcd_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int FIELD_W    = 64;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHR_XY,
    CELL_SHR_X,
    CELL_SHR_Y,
    CELL_SUB,
    CELL_SHL_X
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     swap;
  } cell_ctrl_t;

  typedef struct packed {
    logic x_lsb;
    logic y_lsb;
    logic x_zero;
    logic y_zero;
    logic y_lt_x;
  } chain_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TWOS,
    ST_STRIP,
    ST_LOOP,
    ST_UNDO,
    ST_DONE
  } gcd_state_t;

endpackage
`default_nettype wire

// ===== sv/bgcd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgcd_cell
// One bit slice of the operand pair: holds x and y bits, shifts with its
// neighbors and takes part in the two borrow chains.
// ----------------------------------------------------------------------------
module bgcd_cell (
  input  wire                 clk,
  input  bgcd_pkg::cell_ctrl_t ctrl,
  input  wire                 a_bit,
  input  wire                 b_bit,
  input  wire                 x_up,
  input  wire                 y_up,
  input  wire                 x_dn,
  input  wire                 byx_in,
  input  wire                 bxy_in,
  output logic                x_r,
  output logic                y_r,
  output logic                byx_out,
  output logic                bxy_out
);

  logic x_nxt;
  logic y_nxt;
  logic dyx;
  logic dxy;

  // Ripple borrow for y - x and x - y
  always_comb begin
    dyx     = y_r ^ x_r ^ byx_in;
    byx_out = (~y_r & x_r) | (~(y_r ^ x_r) & byx_in);
    dxy     = x_r ^ y_r ^ bxy_in;
    bxy_out = (~x_r & y_r) | (~(x_r ^ y_r) & bxy_in);
  end

  // Select next bits
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    case (ctrl.op)
      bgcd_pkg::CELL_LOAD: begin
        x_nxt = a_bit;
        y_nxt = b_bit;
      end
      bgcd_pkg::CELL_SHR_XY: begin
        x_nxt = x_up;
        y_nxt = y_up;
      end
      bgcd_pkg::CELL_SHR_X: x_nxt = x_up;
      bgcd_pkg::CELL_SHR_Y: y_nxt = y_up;
      bgcd_pkg::CELL_SUB: begin
        if (ctrl.swap) begin
          x_nxt = y_r;
          y_nxt = dxy;
        end else begin
          y_nxt = dyx;
        end
      end
      bgcd_pkg::CELL_SHL_X: x_nxt = x_dn;
      default: begin
        x_nxt = x_r;
        y_nxt = y_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/bgcd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgcd_ctrl
// Sequencer for the cell chain: strips common twos, reduces, restores twos.
// ----------------------------------------------------------------------------
module bgcd_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_fire,
  input  wire                   out_free,
  input  bgcd_pkg::chain_stat_t stat,
  output bgcd_pkg::cell_ctrl_t  ctrl,
  output logic                  idle,
  output logic                  done
);

  bgcd_pkg::gcd_state_t            state_r;
  bgcd_pkg::gcd_state_t            state_nxt;
  logic [bgcd_pkg::CNT_W-1:0]      cnt_r;
  logic [bgcd_pkg::CNT_W-1:0]      cnt_nxt;

  // Next state and twos count
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      bgcd_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_fire) state_nxt = bgcd_pkg::ST_CHECK;
      end
      bgcd_pkg::ST_CHECK: begin
        if (stat.x_zero || stat.y_zero) state_nxt = bgcd_pkg::ST_DONE;
        else state_nxt = bgcd_pkg::ST_TWOS;
      end
      bgcd_pkg::ST_TWOS: begin
        if (!stat.x_lsb && !stat.y_lsb) cnt_nxt = cnt_r + 1'b1;
        else state_nxt = bgcd_pkg::ST_STRIP;
      end
      bgcd_pkg::ST_STRIP: begin
        if (stat.x_lsb) state_nxt = bgcd_pkg::ST_LOOP;
      end
      bgcd_pkg::ST_LOOP: begin
        if (stat.y_zero) state_nxt = bgcd_pkg::ST_UNDO;
      end
      bgcd_pkg::ST_UNDO: begin
        if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
        else state_nxt = bgcd_pkg::ST_DONE;
      end
      bgcd_pkg::ST_DONE: begin
        if (out_free) state_nxt = bgcd_pkg::ST_IDLE;
      end
      default: state_nxt = bgcd_pkg::ST_IDLE;
    endcase
  end

  // Cell commands and handshake flags
  always_comb begin
    ctrl.op   = bgcd_pkg::CELL_HOLD;
    ctrl.swap = 1'b0;
    idle      = 1'b0;
    done      = 1'b0;
    case (state_r)
      bgcd_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (in_fire) ctrl.op = bgcd_pkg::CELL_LOAD;
      end
      bgcd_pkg::ST_TWOS: begin
        if (!stat.x_lsb && !stat.y_lsb) ctrl.op = bgcd_pkg::CELL_SHR_XY;
      end
      bgcd_pkg::ST_STRIP: begin
        if (!stat.x_lsb) ctrl.op = bgcd_pkg::CELL_SHR_X;
      end
      bgcd_pkg::ST_LOOP: begin
        if (!stat.y_zero) begin
          if (!stat.y_lsb) begin
            ctrl.op = bgcd_pkg::CELL_SHR_Y;
          end else begin
            ctrl.op   = bgcd_pkg::CELL_SUB;
            ctrl.swap = stat.y_lt_x;
          end
        end
      end
      bgcd_pkg::ST_UNDO: begin
        if (cnt_r != '0) ctrl.op = bgcd_pkg::CELL_SHL_X;
      end
      bgcd_pkg::ST_DONE: done = out_free;
      default: ctrl.op = bgcd_pkg::CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bgcd_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/binary_gcd.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_gcd
// Greatest common divisor of two unsigned operands by the binary method.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one transfer carries operand_a (low 64 bits of in_tdata)
//   and operand_b (high 64 bits). Only the low DATA_WIDTH bits are used.
//   Output stream: one transfer per input carries the divisor in out_tdata.
//   The operands live in a row of DATA_WIDTH bit cells; each cycle the
//   sequencer tells every cell to load, hold, shift right, shift left, or
//   subtract through the borrow chain. One item is worked at a time.
//   A zero operand goes straight to the result; otherwise the sequencer
//   strips the common twos, then the extra twos of operand_a, runs the
//   halving plus subtract steps of the reduction loop and restores the
//   common twos. The next item is accepted in the cycle after the
//   result is loaded.
//   in_tready is high while the sequencer is idle. The result sits in an
//   output register; a stalled receiver holds it there and the next item
//   may be accepted meanwhile, but it finishes only once the register is
//   free. Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module binary_gcd (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [127:0] in_tdata,   // [63:0] operand_a, [127:64] operand_b
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [63:0]  out_tdata   // [63:0] divisor
);

  localparam int W = bgcd_pkg::DATA_WIDTH;

  logic                  in_fire;
  logic                  out_free;
  logic                  done;
  logic                  idle;
  bgcd_pkg::cell_ctrl_t  ctrl;
  bgcd_pkg::chain_stat_t stat;
  logic [W-1:0]          x_v;
  logic [W-1:0]          y_v;
  logic [W:0]            byx_c;
  logic [W:0]            bxy_c;
  logic                  out_tvalid_r;
  logic [63:0]           out_tdata_r;

  assign in_tready = idle;
  assign in_fire   = in_tvalid & idle;
  assign out_free  = ~out_tvalid_r | out_tready;

  assign byx_c[0] = 1'b0;
  assign bxy_c[0] = 1'b0;

  // Row of bit cells
  genvar i;
  generate
    for (i = 0; i < W; i++) begin : g_cell
      logic x_up;
      logic y_up;
      logic x_dn;
      if (i == W - 1) begin : g_top
        assign x_up = 1'b0;
        assign y_up = 1'b0;
      end else begin : g_mid
        assign x_up = x_v[i+1];
        assign y_up = y_v[i+1];
      end
      if (i == 0) begin : g_bot
        assign x_dn = 1'b0;
      end else begin : g_upr
        assign x_dn = x_v[i-1];
      end
      bgcd_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .a_bit   (in_tdata[i]),
        .b_bit   (in_tdata[64+i]),
        .x_up    (x_up),
        .y_up    (y_up),
        .x_dn    (x_dn),
        .byx_in  (byx_c[i]),
        .bxy_in  (bxy_c[i]),
        .x_r     (x_v[i]),
        .y_r     (y_v[i]),
        .byx_out (byx_c[i+1]),
        .bxy_out (bxy_c[i+1])
      );
    end
  endgenerate

  // Chain status for the sequencer
  always_comb begin
    stat.x_lsb  = x_v[0];
    stat.y_lsb  = y_v[0];
    stat.x_zero = ~|x_v;
    stat.y_zero = ~|y_v;
    stat.y_lt_x = byx_c[W];
  end

  bgcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl),
    .idle     (idle),
    .done     (done)
  );

  // Output register: y is zero at the end, or one operand was zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) out_tdata_r <= 64'(x_v | y_v);
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire

// ===== sv/bgcd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bgcd_checker
// Port-level checks for binary_gcd, bound to the top level.
// ----------------------------------------------------------------------------
module bgcd_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         in_tvalid,
  input wire         in_tready,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [63:0]  out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Busy after an accepted item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted item while busy");

  // No result right after an accept unless one was already waiting
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared too early");

  // Reset clears the output
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind binary_gcd bgcd_checker u_bgcd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

// ===== sim/gcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_checker
// Watches both streams of the GCD block, predicts each divisor from the
// accepted operand pair and compares every result transfer in order.
// ----------------------------------------------------------------------------
module gcd_checker (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  input  wire          in_tready,
  input  wire  [127:0] in_tdata,
  input  wire          out_tvalid,
  input  wire          out_tready,
  input  wire  [63:0]  out_tdata,
  output int           fail_count,
  output int           pending,
  output int           result_count
);

  logic [63:0] divisor_q[$];

  // Stein's method on the low DATA_WIDTH bits
  function automatic logic [63:0] stein_gcd(logic [63:0] a_in, logic [63:0] b_in);
    logic [63:0] msk;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    int          twos;
    msk  = {64{1'b1}} >> (64 - bgcd_pkg::DATA_WIDTH);
    x    = a_in & msk;
    y    = b_in & msk;
    twos = 0;
    if (x == 0) return y;
    if (y == 0) return x;
    while (((x | y) & 1) == 0) begin
      x = x >> 1;
      y = y >> 1;
      twos++;
    end
    while (x[0] == 1'b0) x = x >> 1;
    while (y != 0) begin
      while (y[0] == 1'b0) y = y >> 1;
      if (x > y) begin
        t = x;
        x = y;
        y = t;
      end
      y = y - x;
    end
    return (x << twos) & msk;
  endfunction

  assign pending = divisor_q.size();

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    logic [63:0] exp_div;
    if (!rst_n) begin
      fail_count   <= 0;
      result_count <= 0;
    end else begin
      if (in_tvalid && in_tready)
        divisor_q = {divisor_q, stein_gcd(in_tdata[63:0], in_tdata[127:64])};
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (divisor_q.size() == 0) begin
          $error("unexpected result: divisor actual %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_div = divisor_q.pop_front();
          if (exp_div !== out_tdata) begin
            $error("divisor mismatch: expected %h actual %h", exp_div, out_tdata);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/tb_binary_gcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_gcd
// Drives operand pairs into the GCD block under random gaps and back
// pressure and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_binary_gcd;
  localparam int RANDOM_ITEMS = 1130;
  localparam int CYCLE_LIMIT  = 2000000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [127:0]  in_tdata = '0;
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [63:0]   out_tdata;
  int            fail_count;
  int            pending;
  int            result_count;
  int            sent_count = 0;
  int            cycle_count = 0;
  bit            long_hold = 1'b0;

  always #5 clk = ~clk;

  binary_gcd DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  gcd_checker u_gcd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random operand, sometimes zero, else with a random count of trailing zeros and random magnitude
  function automatic logic [63:0] shaped_operand();
    logic [63:0] v;
    int          mode;
    v    = rand64();
    mode = $urandom_range(0, 9);
    if (mode < 3) v = v >> $urandom_range(0, 63);
    else if (mode < 5) v = v << $urandom_range(0, 63);
    else if (mode == 5) v = 64'd0;
    return v;
  endfunction

  // Offer one pair and hold it until the transfer happens
  task automatic send_pair(logic [63:0] a, logic [63:0] b);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (!rst_n || long_hold) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 3) != 0) || (cycle_count[10:9] == 2'b01);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] g;
    int          burst;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zeros, extremes, equal operands, powers of two
    send_pair(64'd0, 64'd0);
    send_pair(64'd0, 64'd12345);
    send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
    send_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_pair(64'h8000_0000_0000_0000, 64'd1);
    send_pair(64'd1, 64'd1);
    send_pair(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000);
    send_pair(64'd48, 64'd18);
    send_pair(64'd17, 64'd17);
    send_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_pair(64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_pair(64'd10946, 64'd17711);
    send_pair(64'hB000_0000_0000_0000, 64'h3000_0000_0000_0000);
    go_idle();

    // Sender pauses until everything has drained
    while (pending != 0) @(posedge clk);

    // Receiver holds off for a long stretch while the sender keeps offering
    long_hold = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      begin
        repeat (6) send_pair(rand64(), rand64());
        go_idle();
      end
    join

    // Random: bursts with gaps; many pairs share a random common factor
    while (sent_count < RANDOM_ITEMS + 22) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        a = shaped_operand();
        b = shaped_operand();
        if ($urandom_range(0, 2) == 0) begin
          g = rand64() >> $urandom_range(32, 63);
          a = (a >> 32) * g;
          b = (b >> 32) * g;
        end else if ($urandom_range(0, 19) == 0) begin
          b = a;
        end
        send_pair(a, b);
      end
      if ($urandom_range(0, 1) == 0) go_idle();
      else begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Covered %0d operand pairs (zeros, extremes, equal and shared-factor pairs)",
             sent_count);
    $display("with %0d results checked under random gaps and stalls.", result_count);
    if (fail_count == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
